/* sv/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, codes and the key mix for the linear-probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SlotW   = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned LimitW  = 10;

  // stream widths
  localparam int unsigned SDataW = 64;
  localparam int unsigned MDataW = 56;
  localparam int unsigned OutPadW = MDataW - (ValW + SlotW + CountW);

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned QueueDepth    = 2;   // power of two

  localparam logic [LimitW-1:0] LoadLimitReset = 10'd768;

  localparam logic [31:0] MixMul = 32'd16389;

  // request kinds
  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_FIND   = 2'd1;
  localparam logic [OpW-1:0] OP_ERASE  = 2'd2;

  // result status
  localparam logic [StatusW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatusW-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] STAT_DUPLICATE = 2'd2;
  localparam logic [StatusW-1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]         op;
    logic signed [KeyW-1:0] key;
    logic [ValW-1:0]        value;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValW-1:0]    found_value;
    logic [SlotW-1:0]   slot;
    logic [CountW-1:0]  element_count;
  } res_t;

  // first half of the mix: add/xor/add/xor
  function automatic logic [31:0] mix_lo(input logic [31:0] k);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = k + ~(k << 15);
    b = a ^ (a >> 10);
    c = b + (b << 3);
    return c ^ (c >> 6);
  endfunction

  // second half: constant multiply, fold high half down
  function automatic logic [31:0] mix_hi(input logic [31:0] d);
    logic [31:0] e;
    e = d * MixMul;
    return e ^ (e >> 16);
  endfunction

endpackage

/* sv/linear_probe_hash_table.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing: insert, find, erase.
// ----------------------------------------------------------------------------
// The probe walks N slots (1 .. TableDepth) from the home slot; full and
//   unknown-op items skip the probe. The probe loop reads one slot per
//   cycle from the slot memories (registered read, one read port); the
//   engine takes its next request only after the result is registered.
// Reset: async, active low. Afterwards a clearing pass zeroes the occupancy
//   memory with s_tready low; config writes are taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int unsigned TableDepth = lpht_pkg::TableDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lpht_pkg::SDataW-1:0]   s_tdata,   // key[31:0], value[63:32]
  input  logic [lpht_pkg::OpW-1:0]      s_tuser,   // op[1:0]
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lpht_pkg::MDataW-1:0]   m_tdata,   // found_value[31:0],
                                                   // slot[41:32],
                                                   // element_count[52:42], zero pad
  output logic [lpht_pkg::StatusW-1:0]  m_tuser,   // status[1:0]
  // load limit register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpht_pkg::LimitW-1:0]   cfg_data_i
);
  import lpht_pkg::*;

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned QW    = $bits(req_t) + AddrW;

  logic [LimitW-1:0] load_limit_q;

  req_t             s_req;
  logic             clearing;

  // front -> queue
  logic             f_valid, f_ready;
  req_t             f_req;
  logic [AddrW-1:0] f_home;

  // queue -> back
  logic             q_valid, q_ready;
  logic [QW-1:0]    q_data;
  req_t             q_req;
  logic [AddrW-1:0] q_home;

  res_t             res;

  // config register: always writable, block is idle by contract
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_limit_q <= LoadLimitReset;
    end else if (cfg_valid_i) begin
      load_limit_q <= cfg_data_i;
    end
  end

  // unpack request
  assign s_req.op    = s_tuser;
  assign s_req.key   = s_tdata[KeyW-1:0];
  assign s_req.value = s_tdata[KeyW+ValW-1:KeyW];

  // intake: hash in two stages
  lpht_front #(.AddrW(AddrW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clearing_i (clearing),
    .s_valid_i  (s_tvalid),
    .s_ready_o  (s_tready),
    .s_req_i    (s_req),
    .m_valid_o  (f_valid),
    .m_ready_i  (f_ready),
    .m_req_o    (f_req),
    .m_home_o   (f_home)
  );

  // decouples hashing from probing
  lpht_fifo #(.Width(QW), .Depth(QueueDepth)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   ({f_home, f_req}),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  assign q_req  = q_data[$bits(req_t)-1:0];
  assign q_home = q_data[QW-1:$bits(req_t)];

  // probe engine with slot memories and result register
  lpht_back #(.TableDepth(TableDepth)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_limit_i (load_limit_q),
    .clearing_o   (clearing),
    .q_valid_i    (q_valid),
    .q_ready_o    (q_ready),
    .q_req_i      (q_req),
    .q_home_i     (q_home),
    .m_valid_o    (m_tvalid),
    .m_ready_i    (m_tready),
    .m_res_o      (res)
  );

  // pack result
  assign m_tdata = {{OutPadW{1'b0}}, res.element_count, res.slot, res.found_value};
  assign m_tuser = res.status;

endmodule

/* sv/lpht_ram.sv */
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/lpht_front.sv */
// ----------------------------------------------------------------------------
// lpht_front
// Request intake: two-stage key mix producing the home slot.
// ----------------------------------------------------------------------------
module lpht_front #(
  parameter int unsigned AddrW = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clearing_i,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  lpht_pkg::req_t      s_req_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output lpht_pkg::req_t      m_req_o,
  output logic [AddrW-1:0]    m_home_o
);
  import lpht_pkg::*;

  logic             v1_q, v2_q;
  req_t             req1_q, req2_q;
  logic [31:0]      mid1_q;
  logic [31:0]      mixed;
  logic [AddrW-1:0] home2_q;
  logic             ready1, ready2, take;

  assign ready2    = !v2_q || m_ready_i;
  assign ready1    = !v1_q || ready2;
  assign s_ready_o = ready1 && !clearing_i;
  assign take      = s_valid_i && s_ready_o;
  assign mixed     = mix_hi(mid1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= take;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req1_q <= s_req_i;
      mid1_q <= mix_lo(s_req_i.key);
    end
    if (v1_q && ready2) begin
      req2_q  <= req1_q;
      home2_q <= mixed[AddrW-1:0];
    end
  end

  assign m_valid_o = v2_q;
  assign m_req_o   = req2_q;
  assign m_home_o  = home2_q;

endmodule

/* sv/lpht_fifo.sv */
// ----------------------------------------------------------------------------
// lpht_fifo
// Short queue between intake and probe engine.
// ----------------------------------------------------------------------------
module lpht_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2     // power of two
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign in_ready_o  = cnt_q != CntW'(Depth);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= in_data_i;
    end
  end

endmodule

/* sv/lpht_back.sv */
// ----------------------------------------------------------------------------
// lpht_back
// Probe engine: clears the occupancy memory, walks the ring, owns results.
// ----------------------------------------------------------------------------
module lpht_back #(
  parameter int unsigned TableDepth = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [lpht_pkg::LimitW-1:0]     load_limit_i,
  output logic                            clearing_o,
  input  logic                            q_valid_i,
  output logic                            q_ready_o,
  input  lpht_pkg::req_t                  q_req_i,
  input  logic [$clog2(TableDepth)-1:0]   q_home_i,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output lpht_pkg::res_t                  m_res_o
);
  import lpht_pkg::*;

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned LiveW = AddrW + 1;
  localparam int unsigned CmpW  = (LiveW > LimitW) ? LiveW : LimitW;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [AddrW-1:0]   clr_q, clr_d;
  logic [LiveW-1:0]   live_q, live_d;
  logic               out_valid_q, out_valid_d;
  res_t               out_res_q, out_res_d;
  req_t               req_q, req_d;
  logic [AddrW-1:0]   idx_q, idx_d;
  logic [AddrW-1:0]   cnt_q, cnt_d;
  logic [StatusW-1:0] stat_q, stat_d;
  logic [ValW-1:0]    fval_q, fval_d;
  logic [AddrW-1:0]   slot_q, slot_d;

  logic               occ_we, occ_wdata, occ_rd;
  logic [AddrW-1:0]   occ_waddr, rd_addr;
  logic               kv_we;
  logic [ValW+KeyW-1:0] kv_rd;
  logic               key_hit, last, full;

  lpht_ram #(.Width(1), .Depth(TableDepth)) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .raddr_i (rd_addr),
    .rdata_o (occ_rd)
  );

  lpht_ram #(.Width(ValW + KeyW), .Depth(TableDepth)) u_kv_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (idx_q),
    .wdata_i ({req_q.value, req_q.key}),
    .raddr_i (rd_addr),
    .rdata_o (kv_rd)
  );

  assign key_hit    = kv_rd[KeyW-1:0] == $unsigned(req_q.key);
  assign last       = cnt_q == {AddrW{1'b1}};
  assign full       = CmpW'(live_q) >= CmpW'(load_limit_i);
  assign q_ready_o  = state_q == S_IDLE;
  assign clearing_o = state_q == S_CLEAR;
  assign rd_addr    = (state_q == S_IDLE) ? q_home_i : idx_q + AddrW'(1);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    live_d      = live_q;
    req_d       = req_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    stat_d      = stat_q;
    fval_d      = fval_q;
    slot_d      = slot_q;
    out_res_d   = out_res_q;
    out_valid_d = out_valid_q && !m_ready_i;
    occ_we      = 1'b0;
    occ_waddr   = idx_q;
    occ_wdata   = 1'b0;
    kv_we       = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == {AddrW{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          req_d  = q_req_i;
          idx_d  = q_home_i;
          cnt_d  = '0;
          fval_d = '0;
          slot_d = '0;
          case (q_req_i.op) inside
            OP_INSERT: begin
              if (full) begin
                stat_d  = STAT_FULL;
                state_d = S_RESP;
              end else begin
                state_d = S_PROBE;
              end
            end
            OP_FIND, OP_ERASE: begin
              state_d = S_PROBE;
            end
            default: begin
              stat_d  = STAT_NOT_FOUND;
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_PROBE: begin
        idx_d = idx_q + AddrW'(1);
        cnt_d = cnt_q + AddrW'(1);
        if (req_q.op == OP_INSERT) begin
          if (!occ_rd) begin
            occ_we    = 1'b1;
            occ_wdata = 1'b1;
            kv_we     = 1'b1;
            live_d    = live_q + LiveW'(1);
            stat_d    = STAT_OK;
            slot_d    = idx_q;
            state_d   = S_RESP;
          end else if (key_hit) begin
            stat_d  = STAT_DUPLICATE;
            state_d = S_RESP;
          end else if (last) begin
            stat_d  = STAT_FULL;
            state_d = S_RESP;
          end
        end else begin
          if (occ_rd && key_hit) begin
            stat_d  = STAT_OK;
            slot_d  = idx_q;
            state_d = S_RESP;
            if (req_q.op == OP_FIND) begin
              fval_d = kv_rd[ValW+KeyW-1:KeyW];
            end else begin
              occ_we = 1'b1;
              if (live_q != '0) begin
                live_d = live_q - LiveW'(1);
              end
            end
          end else if (last) begin
            stat_d  = STAT_NOT_FOUND;
            state_d = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_q || m_ready_i) begin
          out_valid_d = 1'b1;
          out_res_d   = '{status:        stat_q,
                          found_value:   fval_q,
                          slot:          SlotW'(slot_q),
                          element_count: CountW'(live_q)};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    idx_q     <= idx_d;
    cnt_q     <= cnt_d;
    stat_q    <= stat_d;
    fval_q    <= fval_d;
    slot_q    <= slot_d;
    out_res_q <= out_res_d;
  end

  assign m_valid_o = out_valid_q;
  assign m_res_o   = out_res_q;

endmodule

/* sv/lpht_checker.sv */
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks for the hash table, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [lpht_pkg::MDataW-1:0]   m_tdata,
  input logic [lpht_pkg::StatusW-1:0]  m_tuser
);
  import lpht_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // failures report slot zero
  a_fail_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser != STAT_OK |-> m_tdata[41:32] == '0)
    else $error("nonzero slot on failed request");

  // failures report no value
  a_fail_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser != STAT_OK |-> m_tdata[31:0] == '0)
    else $error("nonzero value on failed request");

  // clearing pass holds off requests right after reset
  a_clear_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !s_tready)
    else $error("request accepted during clearing pass");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
